// ===== rtl/jrsa_pkg.sv =====
// ----------------------------------------------------------------------------
// jrsa_pkg: shared types and constants for the stick rate servo angle block
// Transaction payload structs, register indexes, reset values and the fixed
// constants of the rate and neck mapping arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package jrsa_pkg;

  // Field widths
  localparam int STICK_W    = 8;
  localparam int DT_W       = 16;
  localparam int RATE_W     = 10;
  localparam int DZ_W       = 8;
  localparam int DEG_W      = 8;
  localparam int PDEG_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Arithmetic widths: |stick| * rate fits 18 bits, times dt fits 34 bits
  localparam int MAG_W  = 8;
  localparam int MR_W   = MAG_W + RATE_W;
  localparam int PROD_W = MR_W + DT_W;
  localparam int REM_W  = 17;

  // Divisor: 128 counts full scale times 1000 ms per second
  localparam logic [REM_W-1:0] FULL_SCALE = 17'd128000;

  // Angle limits and reset angles in whole degrees
  localparam int YAW_MAX_DEG     = 180;
  localparam int PITCH_MAX_DEG   = 270;
  localparam int YAW_RESET_DEG   = 95;
  localparam int PITCH_RESET_DEG = 90;

  // Neck mapping constants
  localparam logic [PDEG_W-1:0] MAP_LOW   = 9'd90;
  localparam logic [PDEG_W-1:0] MAP_MID   = 9'd180;
  localparam logic [10:0]       TOP_SLOPE = 11'd17;    // 170/90 reduced to 17/9
  localparam logic [23:0]       RECIP_9   = 24'd7282;  // ceil(2^16 / 9)
  localparam int                RECIP_SH  = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_YAW_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 2'd2;

  // Register reset values
  localparam logic [RATE_W-1:0] RATE_RESET = 10'd180;
  localparam logic [DZ_W-1:0]   DZ_RESET   = 8'd13;

  // Input transaction payload
  typedef struct packed {
    logic signed [STICK_W-1:0] stick_x;
    logic signed [STICK_W-1:0] stick_y;
    logic [DT_W-1:0]           dt_ms;
    logic                      connected;
    logic                      button_level;
  } jrsa_in_t;

  // Output transaction payload
  typedef struct packed {
    logic [DEG_W-1:0] yaw_deg;
    logic [DEG_W-1:0] neck_top_deg;
    logic [DEG_W-1:0] neck_bottom_deg;
    logic             test_start;
  } jrsa_out_t;

endpackage

`default_nettype wire

// ===== rtl/joystick_rate_servo_angles.sv =====
// ----------------------------------------------------------------------------
// joystick_rate_servo_angles: stick driven yaw and neck servo angles
// Integrates two stick axes into fixed point yaw and pitch angles, clamps
// them, maps pitch onto two neck servos and flags button presses.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-----------------------
//   in      | input     | in_valid / in_ready    | jrsa_in_t  in_data
//   out     | output    | out_valid / out_ready  | jrsa_out_t out_data
//   cfg     | input     | cfg_write, no wait     | cfg_index, cfg_data
//
// Items are not overlapped: an item is accepted only after the last one has
// passed the shift-add dt multiply, the bit-serial divider by 128000 (one
// quotient bit a cycle, the longest step), the clamp and the result load.
// An item with connected clear is accepted and dropped while the block stays idle.
// Reset is synchronous; there is no clearing pass.
// A stalled output holds its result while the next item is already processed;
// only the final result load waits for the output register to free up.
//
`default_nettype none

module joystick_rate_servo_angles #(
  parameter int ANGLE_FRAC_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  jrsa_pkg::jrsa_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output jrsa_pkg::jrsa_out_t                    out_data,
  input  logic                                   cfg_write,
  input  logic [jrsa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [jrsa_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import jrsa_pkg::*;

  localparam int F       = ANGLE_FRAC_BITS;
  localparam int DIV_W   = PROD_W + F;
  localparam int CLAMP_W = DIV_W + 1;
  localparam int YAW_W   = DEG_W + F;
  localparam int PITCH_W = PDEG_W + F;
  localparam int CNT_W   = $clog2(DIV_W + 1);

  localparam logic [CLAMP_W-1:0] YAW_HI   = CLAMP_W'(YAW_MAX_DEG) << F;
  localparam logic [CLAMP_W-1:0] PITCH_HI = CLAMP_W'(PITCH_MAX_DEG) << F;
  localparam logic [YAW_W-1:0]   YAW_RST  = YAW_W'(YAW_RESET_DEG) << F;
  localparam logic [PITCH_W-1:0] PITCH_RST = PITCH_W'(PITCH_RESET_DEG) << F;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CLAMP,
    S_MAP
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;

  // Configuration registers
  logic [RATE_W-1:0] yaw_rate;
  logic [RATE_W-1:0] pitch_rate;
  logic [DZ_W-1:0]   deadzone;

  // Per-item working registers, x lane drives yaw, y lane drives pitch
  logic [DT_W-1:0]    dt_sh;
  logic [MR_W-1:0]    mr_x, mr_y;
  logic               neg_x, neg_y;
  logic [PROD_W-1:0]  acc_x, acc_y;
  logic [DIV_W-1:0]   div_x, div_y;
  logic [REM_W-1:0]   rem_x, rem_y;
  logic [DIV_W-1:0]   quo_x, quo_y;
  logic               start_pending;

  // Persistent state
  logic [YAW_W-1:0]   yaw_angle;
  logic [PITCH_W-1:0] pitch_angle;
  logic               button_prev;

  // Stick magnitude with deadzone, and magnitude times rate
  logic [MAG_W-1:0] abs_x, abs_y, mag_x, mag_y;
  logic [MR_W-1:0]  mr_x_next, mr_y_next;

  always_comb begin
    abs_x = in_data.stick_x[STICK_W-1] ? MAG_W'(~in_data.stick_x + 1'b1)
                                       : MAG_W'(in_data.stick_x);
    abs_y = in_data.stick_y[STICK_W-1] ? MAG_W'(~in_data.stick_y + 1'b1)
                                       : MAG_W'(in_data.stick_y);
    mag_x = (abs_x < deadzone) ? '0 : abs_x;
    mag_y = (abs_y < deadzone) ? '0 : abs_y;
    mr_x_next = MR_W'(mag_x) * MR_W'(yaw_rate);
    mr_y_next = MR_W'(mag_y) * MR_W'(pitch_rate);
  end

  // Shift-add multiply step, dt consumed most significant bit first
  logic [PROD_W-1:0] acc_x_next, acc_y_next;

  always_comb begin
    acc_x_next = {acc_x[PROD_W-2:0], 1'b0} + (dt_sh[DT_W-1] ? PROD_W'(mr_x) : '0);
    acc_y_next = {acc_y[PROD_W-2:0], 1'b0} + (dt_sh[DT_W-1] ? PROD_W'(mr_y) : '0);
  end

  // Restoring division step by the full scale constant
  logic [REM_W:0]   rsh_x, rsh_y;
  logic             ge_x, ge_y;
  logic [REM_W-1:0] rem_x_next, rem_y_next;

  always_comb begin
    rsh_x = {rem_x, div_x[DIV_W-1]};
    rsh_y = {rem_y, div_y[DIV_W-1]};
    ge_x  = rsh_x >= {1'b0, FULL_SCALE};
    ge_y  = rsh_y >= {1'b0, FULL_SCALE};
    rem_x_next = ge_x ? REM_W'(rsh_x - {1'b0, FULL_SCALE}) : rsh_x[REM_W-1:0];
    rem_y_next = ge_y ? REM_W'(rsh_y - {1'b0, FULL_SCALE}) : rsh_y[REM_W-1:0];
  end

  // Angle update with clamping to the axis range
  logic [CLAMP_W-1:0] ext_x, ext_y, dq_x, dq_y;
  logic [CLAMP_W-1:0] sum_x, sum_y, sub_x, sub_y;
  logic [YAW_W-1:0]   yaw_next;
  logic [PITCH_W-1:0] pitch_next;

  always_comb begin
    ext_x = CLAMP_W'(yaw_angle);
    ext_y = CLAMP_W'(pitch_angle);
    dq_x  = CLAMP_W'(quo_x);
    dq_y  = CLAMP_W'(quo_y);
    sum_x = ext_x + dq_x;
    sum_y = ext_y + dq_y;
    sub_x = ext_x - dq_x;
    sub_y = ext_y - dq_y;
    if (neg_x) begin
      yaw_next = (dq_x > ext_x) ? '0 : YAW_W'(sub_x);
    end else begin
      yaw_next = (sum_x > YAW_HI) ? YAW_W'(YAW_HI) : YAW_W'(sum_x);
    end
    if (neg_y) begin
      pitch_next = (dq_y > ext_y) ? '0 : PITCH_W'(sub_y);
    end else begin
      pitch_next = (sum_y > PITCH_HI) ? PITCH_W'(PITCH_HI) : PITCH_W'(sum_y);
    end
  end

  // Neck mapping from the integer pitch angle
  logic [PDEG_W-1:0] pdeg;
  logic [6:0]        over;
  logic [10:0]       scaled;
  logic [23:0]       recip;
  logic [DEG_W-1:0]  top_deg, bottom_deg;

  always_comb begin
    pdeg   = pitch_angle[PITCH_W-1:F];
    over   = 7'(pdeg - MAP_MID);
    scaled = 11'({4'b0, over} * TOP_SLOPE);
    recip  = 24'(scaled) * RECIP_9;
    if (pdeg <= MAP_LOW) begin
      bottom_deg = DEG_W'(MAP_LOW);
      top_deg    = DEG_W'(MAP_MID - pdeg);
    end else if (pdeg <= MAP_MID) begin
      bottom_deg = pdeg[DEG_W-1:0];
      top_deg    = pdeg[DEG_W-1:0];
    end else begin
      bottom_deg = DEG_W'(MAP_MID);
      top_deg    = DEG_W'(MAP_MID) - recip[RECIP_SH+DEG_W-1:RECIP_SH];
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer, datapath registers and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      out_valid   <= 1'b0;
      yaw_rate    <= RATE_RESET;
      pitch_rate  <= RATE_RESET;
      deadzone    <= DZ_RESET;
      yaw_angle   <= YAW_RST;
      pitch_angle <= PITCH_RST;
      button_prev <= 1'b0;
    end else begin
      // Register writes
      if (cfg_write) begin
        unique case (cfg_index)
          REG_YAW_RATE:   yaw_rate   <= cfg_data;
          REG_PITCH_RATE: pitch_rate <= cfg_data;
          REG_DEADZONE:   deadzone   <= cfg_data[DZ_W-1:0];
          default: ;
        endcase
      end

      // Output transaction completes; in S_MAP the result load decides instead
      if (out_valid && out_ready && state != S_MAP) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && in_data.connected) begin
            mr_x          <= mr_x_next;
            mr_y          <= mr_y_next;
            neg_x         <= in_data.stick_x[STICK_W-1];
            neg_y         <= in_data.stick_y[STICK_W-1];
            dt_sh         <= in_data.dt_ms;
            acc_x         <= '0;
            acc_y         <= '0;
            start_pending <= in_data.button_level & ~button_prev;
            button_prev   <= in_data.button_level;
            cnt           <= '0;
            state         <= S_MUL;
          end
        end
        S_MUL: begin
          acc_x <= acc_x_next;
          acc_y <= acc_y_next;
          dt_sh <= {dt_sh[DT_W-2:0], 1'b0};
          if (cnt == CNT_W'(DT_W - 1)) begin
            div_x <= DIV_W'(acc_x_next) << F;
            div_y <= DIV_W'(acc_y_next) << F;
            rem_x <= '0;
            rem_y <= '0;
            quo_x <= '0;
            quo_y <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          rem_x <= rem_x_next;
          rem_y <= rem_y_next;
          quo_x <= {quo_x[DIV_W-2:0], ge_x};
          quo_y <= {quo_y[DIV_W-2:0], ge_y};
          div_x <= {div_x[DIV_W-2:0], 1'b0};
          div_y <= {div_y[DIV_W-2:0], 1'b0};
          if (cnt == CNT_W'(DIV_W - 1)) begin
            state <= S_CLAMP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CLAMP: begin
          yaw_angle   <= yaw_next;
          pitch_angle <= pitch_next;
          state       <= S_MAP;
        end
        S_MAP: begin
          // Load the result once the output register is free
          if (!out_valid || out_ready) begin
            out_data.yaw_deg         <= yaw_angle[YAW_W-1:F];
            out_data.neck_top_deg    <= top_deg;
            out_data.neck_bottom_deg <= bottom_deg;
            out_data.test_start      <= start_pending;
            out_valid                <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jrsa_checker.sv =====
// ----------------------------------------------------------------------------
// jrsa_checker: port level checks for the stick rate servo angle block
// Watches the transaction ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module jrsa_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input jrsa_pkg::jrsa_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input jrsa_pkg::jrsa_out_t out_data
);
  import jrsa_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // A connected update keeps the block busy for the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.connected |=> !in_ready)
    else $error("input taken again right after a connected update");

  // Servo angles stay within their mechanical ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.yaw_deg <= 8'd180 &&
                  out_data.neck_bottom_deg >= 8'd90 &&
                  out_data.neck_bottom_deg <= 8'd180 &&
                  out_data.neck_top_deg >= 8'd10 &&
                  out_data.neck_top_deg <= 8'd180)
    else $error("servo angle out of range");

endmodule

bind joystick_rate_servo_angles jrsa_checker u_jrsa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for joystick_rate_servo_angles
// Drives stick update transactions through the valid/ready input channel,
// predicts yaw and neck servo angles and the button pulse with a scoreboard
// model of its own, and compares every output transaction field by field.
// Register settings change between phases while the block is idle, and
// sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------

module testbench;

  import jrsa_pkg::*;

  localparam int FRAC_BITS    = 10;
  localparam int SETTLE_CYC   = 80;    // a little more than one item of latency
  localparam int WATCHDOG_CYC = 4000;  // cycles without any transaction
  localparam int PHASE_ITEMS  = 56;

  // Index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // Scoreboard: angle predictor plus the queue of expected servo outputs.
  class servo_scoreboard;
    int unsigned yaw_rate;
    int unsigned pitch_rate;
    int unsigned deadzone;
    longint      yaw_fx;
    longint      pitch_fx;
    bit          button_prev;
    jrsa_out_t   expected_angles[$];
    int          errors;

    function new();
      yaw_rate    = RATE_RESET;
      pitch_rate  = RATE_RESET;
      deadzone    = DZ_RESET;
      yaw_fx      = longint'(YAW_RESET_DEG) << FRAC_BITS;
      pitch_fx    = longint'(PITCH_RESET_DEG) << FRAC_BITS;
      button_prev = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_YAW_RATE: begin
          yaw_rate = data[RATE_W-1:0];
        end
        REG_PITCH_RATE: begin
          pitch_rate = data[RATE_W-1:0];
        end
        REG_DEADZONE: begin
          deadzone = data[DZ_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // One axis: deadzone, rate integration with truncation toward zero, clamp.
    function longint integrate_axis(longint angle, logic signed [STICK_W-1:0] stick,
                                    int unsigned rate, logic [DT_W-1:0] dt, int max_deg);
      int     mag;
      longint prod;
      longint delta;
      mag = (stick < 0) ? -int'(stick) : int'(stick);
      if (mag < deadzone) mag = 0;
      prod  = (longint'(mag) * longint'(rate) * longint'(dt)) << FRAC_BITS;
      delta = prod / longint'(FULL_SCALE);
      if (stick < 0) delta = -delta;
      angle = angle + delta;
      if (angle < 0) angle = 0;
      if (angle > (longint'(max_deg) << FRAC_BITS)) angle = longint'(max_deg) << FRAC_BITS;
      return angle;
    endfunction

    // Accepted input transaction: update the model and queue the expected output.
    function void note_input(jrsa_in_t item);
      jrsa_out_t res;
      int        p;
      int        top;
      int        bottom;
      if (!item.connected) return;
      yaw_fx   = integrate_axis(yaw_fx, item.stick_x, yaw_rate, item.dt_ms, YAW_MAX_DEG);
      pitch_fx = integrate_axis(pitch_fx, item.stick_y, pitch_rate, item.dt_ms,
                                PITCH_MAX_DEG);
      p = int'(pitch_fx >> FRAC_BITS);
      if (p <= 90) begin
        bottom = 90;
        top    = 180 - p;
      end else if (p <= 180) begin
        bottom = p;
        top    = p;
      end else begin
        bottom = 180;
        top    = 180 - ((p - 180) * 170) / 90;
      end
      res.yaw_deg         = DEG_W'(yaw_fx >> FRAC_BITS);
      res.neck_top_deg    = DEG_W'(top);
      res.neck_bottom_deg = DEG_W'(bottom);
      res.test_start      = item.button_level & ~button_prev;
      button_prev         = item.button_level;
      expected_angles.push_back(res);
    endfunction

    // Accepted output transaction: compare with the oldest expectation.
    function void check_result(jrsa_out_t act);
      jrsa_out_t exp_res;
      if (expected_angles.size() == 0) begin
        $error("unexpected output transaction: yaw %0d top %0d bottom %0d start %0d",
               act.yaw_deg, act.neck_top_deg, act.neck_bottom_deg, act.test_start);
        errors++;
        return;
      end
      exp_res = expected_angles.pop_front();
      if (act.yaw_deg !== exp_res.yaw_deg) begin
        $error("yaw_deg: expected %0d, actual %0d", exp_res.yaw_deg, act.yaw_deg);
        errors++;
      end
      if (act.neck_top_deg !== exp_res.neck_top_deg) begin
        $error("neck_top_deg: expected %0d, actual %0d",
               exp_res.neck_top_deg, act.neck_top_deg);
        errors++;
      end
      if (act.neck_bottom_deg !== exp_res.neck_bottom_deg) begin
        $error("neck_bottom_deg: expected %0d, actual %0d",
               exp_res.neck_bottom_deg, act.neck_bottom_deg);
        errors++;
      end
      if (act.test_start !== exp_res.test_start) begin
        $error("test_start: expected %0d, actual %0d", exp_res.test_start, act.test_start);
        errors++;
      end
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  jrsa_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  jrsa_out_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  servo_scoreboard sb = new();

  joystick_rate_servo_angles u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output monitor: every accepted output transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYC) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic jrsa_in_t make_update(int sx, int sy, int dt, bit conn, bit btn);
    jrsa_in_t item;
    item.stick_x      = STICK_W'(sx);
    item.stick_y      = STICK_W'(sy);
    item.dt_ms        = DT_W'(dt);
    item.connected    = conn;
    item.button_level = btn;
    return item;
  endfunction

  // Stick value: mostly anywhere, sometimes right at the deadzone boundary.
  function automatic int pick_stick();
    int v;
    if ($urandom_range(4) == 0) begin
      v = int'(sb.deadzone) - int'($urandom_range(1));
      if ($urandom_range(1)) v = -v;
    end else begin
      v = $urandom_range(255);
    end
    return v;
  endfunction

  function automatic jrsa_in_t random_update();
    int dt;
    case ($urandom_range(9))
      0:       dt = $urandom_range(65535);
      1, 2:    dt = $urandom_range(5000);
      default: dt = $urandom_range(300);
    endcase
    return make_update(pick_stick(), pick_stick(), dt, ($urandom_range(99) < 87),
                       $urandom_range(1));
  endfunction

  // Present one update transaction, with an optional random gap first.
  task automatic send_update(input jrsa_in_t item);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
  endtask

  // Hold the sender off until every expected output has come, then wait out
  // the settle time.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // One phase: new register values, new idling rates, then random updates.
  task automatic run_phase(input int yaw_r, input int pitch_r, input int dz,
                           input int send_pct, input int recv_pct);
    wait_idle();
    cfg_put(REG_YAW_RATE, CFG_DATA_W'(yaw_r));
    cfg_put(REG_PITCH_RATE, CFG_DATA_W'(pitch_r));
    // Upper data bits are random to show that the deadzone register ignores them.
    cfg_put(REG_DEADZONE, {2'($urandom_range(3)), DZ_W'(dz)});
    cfg_put(REG_NONE, CFG_DATA_W'($urandom_range(1023)));
    cfg_write <= 1'b0;
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (PHASE_ITEMS) send_update(random_update());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed updates with the reset register values.
    send_update(make_update(0, 0, 0, 1'b1, 1'b1));           // button press pulse
    send_update(make_update(0, 0, 0, 1'b1, 1'b1));           // held, no pulse
    send_update(make_update(0, 0, 0, 1'b0, 1'b0));           // link down, release ignored
    send_update(make_update(0, 0, 0, 1'b1, 1'b1));           // still held, no pulse
    send_update(make_update(12, -12, 1000, 1'b1, 1'b0));     // just inside the deadzone
    send_update(make_update(13, 13, 1000, 1'b1, 1'b0));      // just outside
    send_update(make_update(-13, -13, 1000, 1'b1, 1'b1));
    send_update(make_update(127, 127, 65535, 1'b1, 1'b0));   // clamp at the top
    send_update(make_update(127, 127, 65535, 1'b1, 1'b1));
    send_update(make_update(-128, -128, 65535, 1'b1, 1'b0)); // clamp at zero
    send_update(make_update(127, 127, 1000, 1'b1, 1'b0));    // middle pitch phase
    send_update(make_update(64, 64, 500, 1'b1, 1'b1));       // upper pitch phase
    send_update(make_update(-1, 1, 65535, 1'b1, 1'b0));
    send_update(make_update(-128, 127, 300, 1'b0, 1'b1));    // link down, large move
    send_update(make_update(0, -128, 100, 1'b1, 1'b1));
    send_update(make_update(127, -128, 1, 1'b1, 1'b0));
    send_update(make_update(-127, 90, 777, 1'b1, 1'b1));
    send_update(make_update(100, -40, 2500, 1'b1, 1'b0));

    // Random phases over several register settings and idling patterns.
    run_phase(180, 180, 13, 0, 0);
    run_phase(0, 0, 0, 79, 0);
    run_phase(720, 720, 128, 0, 79);
    run_phase(1023, 1023, 255, 26, 26);
    run_phase(1, 720, 129, 0, 0);
    run_phase($urandom_range(720), $urandom_range(720), $urandom_range(140), 79, 0);
    run_phase(720, 1, 0, 0, 79);
    run_phase($urandom_range(1023), $urandom_range(1023), $urandom_range(255), 26, 26);

    wait_idle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/jrsa_pkg.sv
rtl/joystick_rate_servo_angles.sv
rtl/jrsa_checker.sv
verif/testbench.sv
